@@ src/ohtu_pkg.sv @@
// ----------------------------------------------------------------------------
// ohtu_pkg
// Shared types, constants and helpers for the opcode histogram / trace unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ohtu_pkg;

    localparam int TRACE_DEPTH_DEF = 1024;
    localparam int COUNT_WIDTH_DEF = 64;

    localparam int NUM_COUNTERS = 1792;
    localparam int SLOT_W       = 11;
    localparam int KIND_W       = 3;
    localparam int CLASS_W      = 3;
    localparam int OP_W         = 8;
    localparam int AGE_W        = 10;
    localparam int FILL_OUT_W   = 11;
    localparam int CNT_OUT_W    = 64;
    localparam int META_W       = 43;
    localparam int TIME_W       = 64;
    localparam int ENTRY_W      = META_W + TIME_W;
    localparam int IN_DATA_W    = 120;
    localparam int OUT_DATA_W   = 184;
    localparam int OUT_PAD_W    = OUT_DATA_W - CNT_OUT_W - ENTRY_W - FILL_OUT_W;

    localparam logic [KIND_W-1:0] KIND_LOG   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TRACE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOTAL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [CLASS_W-1:0] PFX_NONE    = 3'd0;
    localparam logic [CLASS_W-1:0] PFX_UNKNOWN = 3'd7;

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_COUNT = 2'd1,
        RES_TOTAL = 2'd2,
        RES_ENTRY = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic     accept;
        logic     commit;
        logic     do_log;
        logic     wipe;
        logic     sweep;
        res_sel_t res_sel;
    } ohtu_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } ohtu_stat_t;

    // class k lives at k*256; unknown class folds onto no prefix
    function automatic logic [SLOT_W-1:0] counter_slot(input logic [CLASS_W-1:0] cls,
                                                       input logic [OP_W-1:0]    op);
        logic [CLASS_W-1:0] c;
        c = (cls == PFX_UNKNOWN) ? PFX_NONE : cls;
        return {c, op};
    endfunction

endpackage

`default_nettype wire

@@ src/ohtu_ctrl.sv @@
// ----------------------------------------------------------------------------
// ohtu_ctrl
// Sequencer: counter sweep, request accept, execute/commit; holds the
// capture enable register.
// ----------------------------------------------------------------------------
`default_nettype none

module ohtu_ctrl
    import ohtu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [KIND_W-1:0] in_kind,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data,
    output ohtu_cmd_t              cmd,
    input  wire ohtu_stat_t        stat
);

    typedef enum logic [2:0] {
        ST_SWEEP = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t   state_reg, state_next;
    res_sel_t sel_reg, sel_next;
    logic     log_reg, log_next;
    logic     wipe_reg, wipe_next;
    logic     cap_reg;
    logic     accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        sel_next  = sel_reg;
        log_next  = log_reg;
        wipe_next = wipe_reg;
        if (accept)
        begin
            log_next  = 1'b0;
            wipe_next = 1'b0;
            unique case (in_kind)
                KIND_LOG:
                begin
                    sel_next = RES_NONE;
                    log_next = cap_reg;
                end
                KIND_QUERY: sel_next = RES_COUNT;
                KIND_TRACE: sel_next = RES_ENTRY;
                KIND_TOTAL: sel_next = RES_TOTAL;
                KIND_CLEAR:
                begin
                    sel_next  = RES_NONE;
                    wipe_next = 1'b1;
                end
                default: sel_next = RES_NONE;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.commit  = 1'b0;
        cmd.sweep   = 1'b0;
        cmd.do_log  = log_reg;
        cmd.wipe    = wipe_reg;
        cmd.res_sel = sel_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result lands in the output register only when it is free
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = wipe_reg ? ST_SWEEP : ST_IDLE;
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sel_reg   <= RES_NONE;
            log_reg   <= 1'b0;
            wipe_reg  <= 1'b0;
            cap_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            log_reg   <= log_next;
            wipe_reg  <= wipe_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/ohtu_dpath.sv @@
// ----------------------------------------------------------------------------
// ohtu_dpath
// Counter memory, trace ring memories, total / pointer / fill registers and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ohtu_dpath
    import ohtu_pkg::*;
#(
    parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ohtu_cmd_t             cmd,
    output ohtu_stat_t                 stat,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_status
);

    localparam int PTR_W  = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
    localparam int FILL_W = $clog2(TRACE_DEPTH + 1);
    localparam int XW     = PTR_W + 1;
    localparam int ZW     = (FILL_W > AGE_W) ? FILL_W : AGE_W;

    // input fields
    logic [15:0]        in_pc;
    logic [CLASS_W-1:0] in_pfx;
    logic [OP_W-1:0]    in_op;
    logic [7:0]         in_flg;
    logic [7:0]         in_acc;
    logic [31:0]        in_frm;
    logic [31:0]        in_ts;
    logic [AGE_W-1:0]   in_age;

    assign in_pc  = in_data[15:0];
    assign in_pfx = in_data[18:16];
    assign in_op  = in_data[26:19];
    assign in_flg = in_data[34:27];
    assign in_acc = in_data[42:35];
    assign in_frm = in_data[74:43];
    assign in_ts  = in_data[106:75];
    assign in_age = in_data[116:107];

    // captured request
    logic [META_W-1:0]  meta_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic               absent_reg;

    logic [SLOT_W-1:0]      sweep_reg;
    logic [COUNT_WIDTH-1:0] total_reg;
    logic [PTR_W-1:0]       wp_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic                   out_status_reg;

    logic [COUNT_WIDTH-1:0] cnt_mem [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] cnt_rd_reg;
    logic [META_W-1:0]      meta_mem [TRACE_DEPTH];
    logic [TIME_W-1:0]      time_mem [TRACE_DEPTH];
    logic [META_W-1:0]      meta_rd_reg;
    logic [TIME_W-1:0]      time_rd_reg;

    logic                   log_wr;
    logic                   cnt_we;
    logic [SLOT_W-1:0]      cnt_waddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata;
    logic [XW-1:0]          rd_tmp;
    logic [PTR_W-1:0]       rd_idx;
    logic                   age_absent;
    logic [FILL_W-1:0]      fill_next;
    logic [CNT_OUT_W-1:0]   count_out;
    logic [ENTRY_W-1:0]     entry_out;
    logic                   entry_req;

    assign stat.sweep_last = (sweep_reg == SLOT_W'(NUM_COUNTERS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign log_wr    = cmd.commit && cmd.do_log;
    assign cnt_we    = cmd.sweep || log_wr;
    assign cnt_waddr = cmd.sweep ? sweep_reg : slot_reg;
    assign cnt_wdata = cmd.sweep ? '0 : cnt_rd_reg + COUNT_WIDTH'(1);

    // newest entry sits one below the write pointer
    assign rd_tmp = XW'(wp_reg) + XW'(TRACE_DEPTH - 1) - XW'(in_age);
    assign rd_idx = (rd_tmp >= XW'(TRACE_DEPTH)) ? PTR_W'(rd_tmp - XW'(TRACE_DEPTH))
                                                 : PTR_W'(rd_tmp);
    assign age_absent = ZW'(in_age) >= ZW'(fill_reg);

    always_comb
    begin
        if (cmd.wipe)
        begin
            fill_next = '0;
        end
        else if (cmd.do_log && (fill_reg < FILL_W'(TRACE_DEPTH)))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else
        begin
            fill_next = fill_reg;
        end
    end

    always_comb
    begin
        case (cmd.res_sel)
            RES_COUNT: count_out = CNT_OUT_W'(cnt_rd_reg);
            RES_TOTAL: count_out = CNT_OUT_W'(total_reg);
            default:   count_out = '0;
        endcase
    end

    assign entry_req = (cmd.res_sel == RES_ENTRY);
    assign entry_out = (entry_req && !absent_reg) ? {time_rd_reg, meta_rd_reg} : '0;

    // counter memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.accept)
        begin
            cnt_rd_reg <= cnt_mem[counter_slot(in_pfx, in_op)];
        end
    end

    // trace ring memories
    always_ff @(posedge clk)
    begin
        if (log_wr)
        begin
            meta_mem[wp_reg] <= meta_reg;
            time_mem[wp_reg] <= time_reg;
        end
        if (cmd.accept)
        begin
            meta_rd_reg <= meta_mem[rd_idx];
            time_rd_reg <= time_mem[rd_idx];
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            meta_reg   <= {in_acc, in_flg, in_op, in_pfx, in_pc};
            time_reg   <= {in_ts, in_frm};
            slot_reg   <= counter_slot(in_pfx, in_op);
            absent_reg <= age_absent;
        end
        if (cmd.commit)
        begin
            out_data_reg   <= {{OUT_PAD_W{1'b0}}, FILL_OUT_W'(fill_next), entry_out, count_out};
            out_status_reg <= entry_req && absent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg     <= '0;
            total_reg     <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                sweep_reg <= stat.sweep_last ? '0 : sweep_reg + SLOT_W'(1);
            end
            if (cmd.commit && cmd.wipe)
            begin
                total_reg <= '0;
                wp_reg    <= '0;
            end
            else if (log_wr)
            begin
                total_reg <= total_reg + COUNT_WIDTH'(1);
                wp_reg    <= (wp_reg == PTR_W'(TRACE_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
            end
            if (cmd.commit)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

@@ src/opcode_histogram_trace_unit.sv @@
// ----------------------------------------------------------------------------
// opcode_histogram_trace_unit
// Per-opcode execution counters, running total and a trace ring of executed
// instructions, queried over a request/response stream.
// ----------------------------------------------------------------------------
// After the accepting edge a request passes through the execute state and is
// committed into the output register once that register is free; a held response delays it.
// A new request is taken only once the last one has committed, since the counter
// memory is read through a register and updated by read-modify-write.
// A clear request, and reset, start a sweep that zeroes all 1792 counter memory words,
// during which s_tready is low; cfg writes are taken at all times.
// Reset is asynchronous, active low; capture is disabled after reset.
`default_nettype none

module opcode_histogram_trace_unit
    import ohtu_pkg::*;
#(
    parameter int TRACE_DEPTH = TRACE_DEPTH_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // prog_counter, prefix_class, opcode_byte, flag_byte, acc_byte,
    // frame_number, tstate_value, entry_age
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [KIND_W-1:0]     s_tuser,
    // response stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // count_value, entry_pc, entry_prefix, entry_opcode, entry_flags,
    // entry_acc, entry_frame, entry_tstate, fill_level
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // status
    output logic [0:0]                 m_tuser,
    // capture_enable write
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic                  cfg_data
);

    ohtu_cmd_t  cmd;
    ohtu_stat_t stat;
    logic       status;

    ohtu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    ohtu_dpath #(
        .TRACE_DEPTH (TRACE_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (status)
    );

    assign m_tuser = status;

endmodule

`default_nettype wire
